### src/mbsp_pkg.sv
// Shared types and constants for the MIDI byte stream parser.
// Used by every module of the parser; depends on nothing.
package mbsp_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned DataW  = 7;
  localparam int unsigned KindW  = 4;
  localparam int unsigned ChanW  = 4;
  localparam int unsigned ValueW = 14;
  localparam int unsigned ErrW   = 2;
  localparam int unsigned EventW = KindW + ChanW + DataW + ValueW + ErrW;
  localparam int unsigned OutTdataW = ((EventW + 7) / 8) * 8;

  localparam logic [ByteW-1:0] SysexStart = 8'hF0;
  localparam logic [ByteW-1:0] SysexEnd   = 8'hF7;
  localparam logic [3:0]       SysHigh    = 4'hF;

  typedef enum logic [1:0] {
    PH_READY  = 2'd0,
    PH_STATUS = 2'd1,
    PH_DATA1  = 2'd2
  } phase_t;

  localparam logic [3:0] MK_NOTE_OFF = 4'h8;
  localparam logic [3:0] MK_NOTE_ON  = 4'h9;
  localparam logic [3:0] MK_POLY_AT  = 4'hA;
  localparam logic [3:0] MK_CC       = 4'hB;
  localparam logic [3:0] MK_PROGRAM  = 4'hC;
  localparam logic [3:0] MK_PRESSURE = 4'hD;
  localparam logic [3:0] MK_PITCH    = 4'hE;
  localparam logic [3:0] MK_SYSEX    = 4'hF;

  typedef enum logic [3:0] {
    EV_NOTE_ON    = 4'd0,
    EV_NOTE_OFF   = 4'd1,
    EV_POLY_AT    = 4'd2,
    EV_CC         = 4'd3,
    EV_PROGRAM    = 4'd4,
    EV_PRESSURE   = 4'd5,
    EV_PITCH      = 4'd6,
    EV_SYSEX_DATA = 4'd7,
    EV_SYSEX_END  = 4'd8,
    EV_ERROR      = 4'd9
  } event_kind_t;

  typedef enum logic [1:0] {
    ERR_NONE       = 2'd0,
    ERR_WRONG_PH   = 2'd1,
    ERR_UNFINISHED = 2'd2
  } error_code_t;

  typedef struct packed {
    logic [ErrW-1:0]   error_code;
    logic [ValueW-1:0] value;
    logic [DataW-1:0]  key_or_number;
    logic [ChanW-1:0]  channel;
    logic [KindW-1:0]  event_kind;
  } event_t;

  typedef struct packed {
    logic   emit;
    event_t ev;
  } decode_out_t;

endpackage

### src/mbsp_decode.sv
// Parser state (phase, status kind, channel, first data byte) and the
// single-pass byte decode. Depends on mbsp_pkg.
module mbsp_decode (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      step,
  input  logic [mbsp_pkg::ByteW-1:0] rx_byte,
  output mbsp_pkg::decode_out_t     result
);

  mbsp_pkg::phase_t phase, phase_next;
  logic [3:0] kind, kind_next;
  logic [mbsp_pkg::ChanW-1:0] chan, chan_next;
  logic [mbsp_pkg::DataW-1:0] first_data, first_data_next;

  logic [mbsp_pkg::DataW-1:0] d;
  logic is_sys, is_status, two_byte;

  assign d         = rx_byte[mbsp_pkg::DataW-1:0];
  assign is_sys    = rx_byte[7:4] == mbsp_pkg::SysHigh;
  assign is_status = rx_byte[7] && !is_sys;
  assign two_byte  = kind == mbsp_pkg::MK_NOTE_OFF || kind == mbsp_pkg::MK_NOTE_ON ||
                     kind == mbsp_pkg::MK_POLY_AT  || kind == mbsp_pkg::MK_CC ||
                     kind == mbsp_pkg::MK_PITCH;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= mbsp_pkg::PH_READY;
      kind       <= mbsp_pkg::MK_NOTE_OFF;
      chan       <= '0;
      first_data <= '0;
    end else if (step) begin
      phase      <= phase_next;
      kind       <= kind_next;
      chan       <= chan_next;
      first_data <= first_data_next;
    end
  end

  always_comb begin
    phase_next      = phase;
    kind_next       = kind;
    chan_next       = chan;
    first_data_next = first_data;
    if (is_sys) begin
      if (rx_byte == mbsp_pkg::SysexStart) begin
        kind_next = mbsp_pkg::MK_SYSEX;
      end
    end else if (is_status) begin
      chan_next  = rx_byte[3:0];
      kind_next  = rx_byte[7:4];
      phase_next = mbsp_pkg::PH_STATUS;
    end else if (two_byte) begin
      unique case (phase)
        mbsp_pkg::PH_READY: begin
          phase_next = mbsp_pkg::PH_READY;
        end
        mbsp_pkg::PH_STATUS: begin
          first_data_next = d;
          phase_next      = mbsp_pkg::PH_DATA1;
        end
        default: begin
          phase_next = mbsp_pkg::PH_STATUS;
        end
      endcase
    end
  end

  always_comb begin
    result      = '0;
    result.ev.channel = chan;
    if (is_sys) begin
      if (rx_byte == mbsp_pkg::SysexEnd) begin
        result.emit          = 1'b1;
        result.ev.event_kind = mbsp_pkg::EV_SYSEX_END;
      end
    end else if (is_status) begin
      if (phase != mbsp_pkg::PH_READY && phase != mbsp_pkg::PH_STATUS) begin
        result.emit          = 1'b1;
        result.ev.event_kind = mbsp_pkg::EV_ERROR;
        result.ev.channel    = rx_byte[3:0];
        result.ev.error_code = mbsp_pkg::ERR_UNFINISHED;
      end
    end else begin
      result.emit          = 1'b1;
      result.ev.event_kind = mbsp_pkg::EV_ERROR;
      result.ev.error_code = mbsp_pkg::ERR_WRONG_PH;
      result.ev.value      = mbsp_pkg::ValueW'(d);
      unique case (kind) inside
        mbsp_pkg::MK_NOTE_OFF, mbsp_pkg::MK_NOTE_ON, mbsp_pkg::MK_POLY_AT,
        mbsp_pkg::MK_CC, mbsp_pkg::MK_PITCH: begin
          if (phase == mbsp_pkg::PH_STATUS) begin
            result.emit = 1'b0;
          end else if (phase != mbsp_pkg::PH_READY) begin
            result.ev.error_code    = mbsp_pkg::ERR_NONE;
            result.ev.key_or_number = first_data;
            if (kind == mbsp_pkg::MK_PITCH) begin
              result.ev.event_kind    = mbsp_pkg::EV_PITCH;
              result.ev.key_or_number = '0;
              result.ev.value         = {d, first_data};
            end else if (kind == mbsp_pkg::MK_NOTE_ON) begin
              result.ev.event_kind = (d != '0) ? mbsp_pkg::EV_NOTE_ON
                                               : mbsp_pkg::EV_NOTE_OFF;
            end else if (kind == mbsp_pkg::MK_NOTE_OFF) begin
              result.ev.event_kind = mbsp_pkg::EV_NOTE_OFF;
            end else if (kind == mbsp_pkg::MK_POLY_AT) begin
              result.ev.event_kind = mbsp_pkg::EV_POLY_AT;
            end else begin
              result.ev.event_kind = mbsp_pkg::EV_CC;
            end
          end
        end
        mbsp_pkg::MK_PROGRAM, mbsp_pkg::MK_PRESSURE: begin
          if (phase == mbsp_pkg::PH_STATUS) begin
            result.ev.error_code = mbsp_pkg::ERR_NONE;
            result.ev.event_kind = (kind == mbsp_pkg::MK_PROGRAM) ? mbsp_pkg::EV_PROGRAM
                                                                  : mbsp_pkg::EV_PRESSURE;
          end
        end
        mbsp_pkg::MK_SYSEX: begin
          result.ev.error_code = mbsp_pkg::ERR_NONE;
          result.ev.event_kind = mbsp_pkg::EV_SYSEX_DATA;
        end
        default: begin
          result.ev.error_code = mbsp_pkg::ERR_WRONG_PH;
        end
      endcase
    end
  end

  a_status_sets_phase: assert property (@(posedge clk) disable iff (rst)
    (step && is_status) |=> (phase == mbsp_pkg::PH_STATUS))
    else $error("status byte did not enter status phase");

  a_sysex_start: assert property (@(posedge clk) disable iff (rst)
    (step && rx_byte == mbsp_pkg::SysexStart) |=> (kind == mbsp_pkg::MK_SYSEX))
    else $error("sysex start did not set sysex kind");

  a_err_code_only_on_error: assert property (@(posedge clk) disable iff (rst)
    (result.emit && result.ev.event_kind != mbsp_pkg::EV_ERROR)
      |-> (result.ev.error_code == mbsp_pkg::ERR_NONE))
    else $error("error code on a non-error event");

  a_idle_holds_state: assert property (@(posedge clk) disable iff (rst)
    !step |=> ($stable(phase) && $stable(kind) && $stable(first_data)))
    else $error("parser state changed without a byte");

endmodule

### src/mbsp_out_reg.sv
// Result register for parser events with stream output handshake.
// Depends on mbsp_pkg.
module mbsp_out_reg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          load,
  input  mbsp_pkg::event_t              ev,
  output logic                          free,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // event_kind[3:0], channel[7:4], key_or_number[14:8], value[28:15],
  // error_code[30:29], zero[31]
  output logic [mbsp_pkg::OutTdataW-1:0] m_tdata
);

  logic             valid;
  mbsp_pkg::event_t data;

  assign free     = !valid || m_tready;
  assign m_tvalid = valid;
  assign m_tdata  = mbsp_pkg::OutTdataW'(data);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (m_tready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data <= ev;
    end
  end

endmodule

### src/midi_byte_stream_parser_core.sv
// MIDI byte stream parser: one byte per request in, at most one event out.
// A byte accepted passes the input register, then the result register, before its event is shown.
// Throughput: one byte per cycle while the result side takes events.
// Reset (rst, synchronous): no status, note-off kind, channel 0, both registers empty.
// Depends on mbsp_pkg, mbsp_decode and mbsp_out_reg.
module midi_byte_stream_parser_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // rx_byte[7:0]
  input  logic [mbsp_pkg::ByteW-1:0]     s_tdata,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // event_kind[3:0], channel[7:4], key_or_number[14:8], value[28:15],
  // error_code[30:29], zero[31]
  output logic [mbsp_pkg::OutTdataW-1:0] m_tdata
);

  logic                       in_valid;
  logic [mbsp_pkg::ByteW-1:0] in_byte;
  logic                       out_free;
  logic                       advance;
  mbsp_pkg::decode_out_t      dec;

  assign advance  = in_valid && out_free;
  assign s_tready = !in_valid || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
    end
  end

  mbsp_decode u_decode (
    .clk     (clk),
    .rst     (rst),
    .step    (advance),
    .rx_byte (in_byte),
    .result  (dec)
  );

  mbsp_out_reg u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (advance && dec.emit),
    .ev       (dec.ev),
    .free     (out_free),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule
